/* sv/pfce_pkg.sv */
package pfce_pkg;

  // Fixed formats of the datapath
  localparam int SQ_IN_W  = 50;   // radicand, padded to an even width
  localparam int SQ_OUT_W = 25;   // root of a 49-bit radicand
  localparam int DV_N_W   = 33;   // dividend width
  localparam int DV_D_W   = 25;   // divisor width

  localparam logic [DV_D_W-1:0] CLAMP_Q16   = 25'd6554;
  localparam logic [DV_N_W-1:0] ONE_Q32     = 33'h1_0000_0000;
  localparam logic [DV_N_W-1:0] ONE_Q24     = 33'h0_0100_0000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef enum logic [2:0] {
    CFG_GOAL_X     = 3'd0,
    CFG_GOAL_Y     = 3'd1,
    CFG_RADIUS     = 3'd2,
    CFG_ATT_GAIN   = 3'd3,
    CFG_REP_GAIN   = 3'd4,
    CFG_OBST_COUNT = 3'd5
  } pfce_cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SQG,
    S_SQB,
    S_DIVD,
    S_DIVR,
    S_MUL,
    S_REP,
    S_SUM
  } pfce_state_t;

  // Token handed from cell to cell during the nearest-obstacle scan
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [32:0] best;
    logic [5:0]  cx;
    logic [5:0]  cy;
  } pfce_link_t;

  // Obstacle load broadcast to all cells
  typedef struct packed {
    logic        en;
    logic [2:0]  slot;
    logic [15:0] x;
    logic [15:0] y;
  } pfce_load_t;

  // Squared distance from a cell (integer coords) to a Q8.8 point, Q16.16
  function automatic logic [32:0] sq_dist(input logic [5:0] cx, input logic [5:0] cy,
                                           input logic [15:0] px, input logic [15:0] py);
    logic [15:0] ax, ay, dx, dy;
    logic [31:0] sx, sy;
    ax = {2'b00, cx, 8'h00};
    ay = {2'b00, cy, 8'h00};
    dx = (ax >= px) ? ax - px : px - ax;
    dy = (ay >= py) ? ay - py : py - ay;
    sx = 32'(dx) * 32'(dx);
    sy = 32'(dy) * 32'(dy);
    return 33'(sx) + 33'(sy);
  endfunction

endpackage

/* sv/pfce_cell.sv */
module pfce_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pfce_pkg::pfce_load_t load,
  input  logic [3:0]          count,
  input  pfce_pkg::pfce_link_t link_in,
  output pfce_pkg::pfce_link_t link_out
);
  import pfce_pkg::*;

  localparam logic [6:0] IdxW = 7'(IDX);

  logic [15:0] x_r, y_r;
  logic        in_use;
  logic [32:0] sq_d;
  pfce_link_t  link_r, link_nxt;

  // Store this cell's obstacle on a matching load
  always_ff @(posedge clk) begin
    if (load.en && ({4'b0000, load.slot} == IdxW)) begin
      x_r <= load.x;
      y_r <= load.y;
    end
  end

  // Keep the smaller squared distance, the later entry on a tie
  always_comb begin
    in_use   = ({3'b000, count} > IdxW);
    sq_d     = sq_dist(link_in.cx, link_in.cy, x_r, y_r);
    link_nxt = link_in;
    if (in_use && (!link_in.found || sq_d <= link_in.best)) begin
      link_nxt.best  = sq_d;
      link_nxt.found = 1'b1;
    end
  end

  // Advance the token to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r.valid <= 1'b0;
    end else begin
      link_r.valid <= link_nxt.valid;
    end
    link_r.found <= link_nxt.found;
    link_r.best  <= link_nxt.best;
    link_r.cx    <= link_nxt.cx;
    link_r.cy    <= link_nxt.cy;
  end

  assign link_out = link_r;

endmodule

/* sv/pfce_sqrt.sv */
module pfce_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pfce_pkg::SQ_IN_W-1:0]   radicand,
  output logic                           busy,
  output logic                           done,
  output logic [pfce_pkg::SQ_OUT_W-1:0]  root
);
  import pfce_pkg::*;

  localparam int RemW = SQ_OUT_W + 2;
  localparam int CntW = $clog2(SQ_OUT_W);

  logic [SQ_IN_W-1:0]  rad_r;
  logic [RemW-1:0]     rem_r;
  logic [SQ_OUT_W-1:0] root_r;
  logic [CntW-1:0]     cnt_r;
  logic                busy_r, done_r;
  logic [RemW+1:0]     rem_t, trial;

  // One root bit per cycle
  always_comb begin
    rem_t = {rem_r, rad_r[SQ_IN_W-1 -: 2]};
    trial = (RemW + 2)'({root_r, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CntW'(SQ_OUT_W - 1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[SQ_IN_W-3:0], 2'b00};
      cnt_r <= cnt_r + 1'b1;
      if (rem_t >= trial) begin
        rem_r  <= RemW'(rem_t - trial);
        root_r <= {root_r[SQ_OUT_W-2:0], 1'b1};
      end else begin
        rem_r  <= RemW'(rem_t);
        root_r <= {root_r[SQ_OUT_W-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

/* sv/pfce_div.sv */
module pfce_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pfce_pkg::DV_N_W-1:0]  dividend,
  input  logic [pfce_pkg::DV_D_W-1:0]  divisor,
  output logic                         done,
  output logic [pfce_pkg::DV_N_W-1:0]  quot
);
  import pfce_pkg::*;

  localparam int CntW = $clog2(DV_N_W);

  logic [DV_N_W-1:0] q_r;
  logic [DV_D_W-1:0] dvs_r, rem_r;
  logic [CntW-1:0]   cnt_r;
  logic              busy_r, done_r;
  logic [DV_D_W:0]   rem_t;

  // Restoring division, one quotient bit per cycle
  assign rem_t = {rem_r, q_r[DV_N_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CntW'(DV_N_W - 1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
    if (start) begin
      q_r   <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (rem_t >= {1'b0, dvs_r}) begin
        rem_r <= DV_D_W'(rem_t - {1'b0, dvs_r});
        q_r   <= {q_r[DV_N_W-2:0], 1'b1};
      end else begin
        rem_r <= DV_D_W'(rem_t);
        q_r   <= {q_r[DV_N_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

/* sv/potential_field_cell_eval_unit.sv */
// Result: an evaluate item gives its result after the cell scan and the goal square root when
//   no obstacle repels, after a second root and two divides when one does, plus output stalls.
// Items: one evaluate item at a time; the input stalls through the scan, the shared bit-serial
//   square root and divider, until its result is registered; a load is taken only while idle.
// Reset: synchronous, active low; control and configuration registers return to their reset
//   values, the obstacle table and working registers keep undefined contents until loaded.
module potential_field_cell_eval_unit #(
  parameter int MAX_OBSTACLES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [2:0]  in_slot,
  input  logic [15:0] in_obstacle_x,
  input  logic [15:0] in_obstacle_y,
  input  logic [5:0]  in_cell_x,
  input  logic [5:0]  in_cell_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_cell_x,
  output logic [5:0]  out_cell_y,
  output logic [31:0] out_potential,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import pfce_pkg::*;

  pfce_state_t state_r, state_nxt;

  logic [15:0] goal_x_r, goal_y_r, radius_r, att_gain_r, rep_gain_r;
  logic [3:0]  count_r;

  logic [5:0]  cx_r, cy_r;
  logic        found_r;
  logic [32:0] best_r;
  logic [31:0] rr_r, att_r;
  logic [19:0] invd_r;
  logic [24:0] diff_r;
  logic [33:0] sqv_r;
  logic [40:0] rep_r;
  logic        out_valid_r, out_sat_r;
  logic [5:0]  out_cx_r, out_cy_r;
  logic [31:0] out_pot_r;

  logic                in_acc, repels, out_free;
  logic [41:0]         total;
  logic                sq_start, sq_busy, sq_done;
  logic [SQ_IN_W-1:0]  sq_rad;
  logic [SQ_OUT_W-1:0] sq_root;
  logic                dv_start, dv_done;
  logic [DV_N_W-1:0]   dv_dvd, dv_quot;
  logic [DV_D_W-1:0]   dv_dvs, dclamp;
  logic [24:0]         invr;
  logic [40:0]         att_prod;
  logic [49:0]         diff_prod, rep_prod;

  pfce_load_t load;
  pfce_link_t link [MAX_OBSTACLES+1];

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r   <= 16'd3584;
      goal_y_r   <= 16'd7424;
      radius_r   <= 16'd2560;
      att_gain_r <= 16'd2560;
      rep_gain_r <= 16'd25600;
      count_r    <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (pfce_cfg_idx_t'(cfg_index))
        CFG_GOAL_X:     goal_x_r   <= cfg_data;
        CFG_GOAL_Y:     goal_y_r   <= cfg_data;
        CFG_RADIUS:     radius_r   <= cfg_data;
        CFG_ATT_GAIN:   att_gain_r <= cfg_data;
        CFG_REP_GAIN:   rep_gain_r <= cfg_data;
        CFG_OBST_COUNT: count_r    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Chain of obstacle cells: the scan token walks one cell per cycle
  always_comb begin
    load.en   = in_acc && (in_opcode == OP_LOAD);
    load.slot = in_slot;
    load.x    = in_obstacle_x;
    load.y    = in_obstacle_y;
    link[0].valid = in_acc && (in_opcode == OP_EVAL);
    link[0].found = 1'b0;
    link[0].best  = '0;
    link[0].cx    = in_cell_x;
    link[0].cy    = in_cell_y;
  end

  for (genvar i = 0; i < MAX_OBSTACLES; i++) begin : g_cell
    pfce_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .load     (load),
      .count    (count_r),
      .link_in  (link[i]),
      .link_out (link[i+1])
    );
  end

  pfce_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_rad),
    .busy     (sq_busy),
    .done     (sq_done),
    .root     (sq_root)
  );

  pfce_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_dvd),
    .divisor  (dv_dvs),
    .done     (dv_done),
    .quot     (dv_quot)
  );

  // Next state
  always_comb begin
    repels    = found_r && (radius_r != 16'd0) && (best_r <= {1'b0, rr_r});
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc && (in_opcode == OP_EVAL)) state_nxt = S_SCAN;
      S_SCAN: if (link[MAX_OBSTACLES].valid) state_nxt = S_SQG;
      S_SQG:  if (sq_done) state_nxt = repels ? S_SQB : S_SUM;
      S_SQB:  if (sq_done) state_nxt = S_DIVD;
      S_DIVD: if (dv_done) state_nxt = S_DIVR;
      S_DIVR: if (dv_done) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_REP;
      S_REP:  state_nxt = S_SUM;
      S_SUM:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Unit starts and operand selection
  always_comb begin
    sq_start = 1'b0;
    sq_rad   = '0;
    dv_start = 1'b0;
    dv_dvd   = ONE_Q32;
    dclamp   = (sq_root < CLAMP_Q16) ? CLAMP_Q16 : sq_root;
    dv_dvs   = dclamp;
    case (state_r)
      S_SCAN: begin
        sq_start = link[MAX_OBSTACLES].valid;
        sq_rad   = {1'b0, sq_dist(cx_r, cy_r, goal_x_r, goal_y_r), 16'h0000};
      end
      S_SQG: begin
        sq_start = sq_done && repels;
        sq_rad   = {1'b0, best_r, 16'h0000};
      end
      S_SQB: begin
        dv_start = sq_done;
      end
      S_DIVD: begin
        dv_start = dv_done;
        dv_dvd   = ONE_Q24;
        dv_dvs   = {9'd0, radius_r};
      end
      default: ;
    endcase
  end

  // Datapath products and final sum
  always_comb begin
    att_prod  = 41'(att_gain_r) * 41'(sq_root);
    invr      = dv_quot[24:0];
    diff_prod = 50'(diff_r) * 50'(diff_r);
    rep_prod  = 50'(rep_gain_r) * 50'(sqv_r);
    total     = {10'd0, att_r} + {1'b0, rep_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold the working values of the current item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cx_r <= in_cell_x;
      cy_r <= in_cell_y;
    end
    rr_r <= 32'(radius_r) * 32'(radius_r);
    case (state_r)
      S_SCAN: begin
        found_r <= link[MAX_OBSTACLES].found;
        best_r  <= link[MAX_OBSTACLES].best;
        rep_r   <= '0;
      end
      S_SQG:  if (sq_done) att_r <= att_prod[40:9];
      S_DIVD: if (dv_done) invd_r <= dv_quot[19:0];
      S_DIVR: if (dv_done) begin
        diff_r <= ({5'd0, invd_r} >= invr) ? {5'd0, invd_r} - invr : invr - {5'd0, invd_r};
      end
      S_MUL:  sqv_r <= diff_prod[49:16];
      S_REP:  rep_r <= rep_prod[49:9];
      default: ;
    endcase
  end

  // Output register: load on finish, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_SUM) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if ((state_r == S_SUM) && out_free) begin
      out_cx_r  <= cx_r;
      out_cy_r  <= cy_r;
      out_sat_r <= (total[41:32] != 10'd0);
      out_pot_r <= (total[41:32] != 10'd0) ? 32'hFFFF_FFFF : total[31:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cell_x    = out_cx_r;
  assign out_cell_y    = out_cy_r;
  assign out_potential = out_pot_r;
  assign out_saturated = out_sat_r;

  // Checks
  a_sqrt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |-> !sq_busy) else $error("sqrt restarted while busy");

  a_eval_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_opcode == OP_EVAL)) |=> (state_r == S_SCAN))
    else $error("evaluate did not start a scan");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_SUM))
    else $error("result appeared outside the sum step");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sat_r) |-> (out_pot_r == 32'hFFFF_FFFF))
    else $error("saturated flag without clipped value");

endmodule

/* dv/potential_field_cell_eval_unit_tb.sv */
`timescale 1ns / 100ps

module potential_field_cell_eval_unit_tb;
  import pfce_pkg::*;

  localparam int N_OBST = 8;
  localparam int TAIL_CYCLES = 300;

  typedef struct packed {
    logic [5:0]  cx;
    logic [5:0]  cy;
    logic [31:0] pot;
    logic        sat;
  } cell_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = OP_LOAD;
  logic [2:0]  in_slot = '0;
  logic [15:0] in_obstacle_x = '0;
  logic [15:0] in_obstacle_y = '0;
  logic [5:0]  in_cell_x = '0;
  logic [5:0]  in_cell_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_cell_x;
  logic [5:0]  out_cell_y;
  logic [31:0] out_potential;
  logic        out_saturated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Shadow copy of the block's registers and obstacle table
  logic [15:0] goal_x_q, goal_y_q, radius_q, att_gain_q, rep_gain_q;
  logic [3:0]  obst_count_q;
  logic [15:0] obst_x_q [N_OBST];
  logic [15:0] obst_y_q [N_OBST];
  logic [N_OBST-1:0] obst_loaded;

  cell_result_t expected_cells[$];
  int  error_count = 0;
  bit  rx_idle_enable = 1'b1;
  bit  tx_idle_enable = 1'b1;
  int  hold_off_cycles = 0;

  potential_field_cell_eval_unit uut (.*);

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] cell_dist_sq(input logic [5:0] cx, input logic [5:0] cy,
                                               input logic [15:0] px, input logic [15:0] py);
    logic [63:0] ax, ay, dx, dy;
    ax = {50'd0, cx, 8'd0};
    ay = {50'd0, cy, 8'd0};
    dx = (ax >= px) ? ax - px : px - ax;
    dy = (ay >= py) ? ay - py : py - ay;
    return dx * dx + dy * dy;
  endfunction

  function automatic cell_result_t cell_potential(input logic [5:0] cx, input logic [5:0] cy);
    cell_result_t r;
    logic [63:0] attract, repel, total, best, s, d, inv_d, inv_r, diff, sq;
    int n;
    bit found;
    attract = (64'(att_gain_q) * int_sqrt(cell_dist_sq(cx, cy, goal_x_q, goal_y_q) << 16)) >> 9;
    repel = 0;
    found = 0;
    best = 0;
    n = (obst_count_q > N_OBST) ? N_OBST : obst_count_q;
    for (int i = 0; i < n; i++) begin
      s = cell_dist_sq(cx, cy, obst_x_q[i], obst_y_q[i]);
      if (!found || s <= best) begin
        best = s;
        found = 1;
      end
    end
    if (found && radius_q != 0 && best <= 64'(radius_q) * 64'(radius_q)) begin
      d = int_sqrt(best << 16);
      if (d < CLAMP_Q16) d = CLAMP_Q16;
      inv_d = (64'd1 << 32) / d;
      inv_r = (64'd1 << 24) / radius_q;
      diff = (inv_d >= inv_r) ? inv_d - inv_r : inv_r - inv_d;
      sq = (diff * diff) >> 16;
      repel = (64'(rep_gain_q) * sq) >> 9;
    end
    total = attract + repel;
    r.cx = cx;
    r.cy = cy;
    r.sat = total > 64'hFFFF_FFFF;
    r.pot = r.sat ? 32'hFFFF_FFFF : total[31:0];
    return r;
  endfunction

  // Idle a random number of cycles, about 14 in 100, while sender idling is on
  task automatic tx_gap();
    while (tx_idle_enable && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold one item until taken; then shadow a load or queue its expected result
  task automatic send_item(input logic op, input logic [2:0] slot, input logic [15:0] ox,
                           input logic [15:0] oy, input logic [5:0] cx, input logic [5:0] cy);
    tx_gap();
    in_valid <= 1'b1;
    in_opcode <= op;
    in_slot <= slot;
    in_obstacle_x <= ox;
    in_obstacle_y <= oy;
    in_cell_x <= cx;
    in_cell_y <= cy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_LOAD) begin
      obst_x_q[slot] = ox;
      obst_y_q[slot] = oy;
      obst_loaded[slot] = 1'b1;
    end else begin
      expected_cells.insert(expected_cells.size(), cell_potential(cx, cy));
    end
  endtask

  task automatic load_obstacle(input logic [2:0] slot, input logic [15:0] ox,
                               input logic [15:0] oy);
    send_item(OP_LOAD, slot, ox, oy, 6'($urandom), 6'($urandom));
  endtask

  task automatic eval_cell(input logic [5:0] cx, input logic [5:0] cy);
    send_item(OP_EVAL, 3'($urandom), 16'($urandom), 16'($urandom), cx, cy);
  endtask

  // Drain outstanding results, then let the block settle before a register write
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input pfce_cfg_idx_t idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_GOAL_X:     goal_x_q = data;
      CFG_GOAL_Y:     goal_y_q = data;
      CFG_RADIUS:     radius_q = data;
      CFG_ATT_GAIN:   att_gain_q = data;
      CFG_REP_GAIN:   rep_gain_q = data;
      CFG_OBST_COUNT: obst_count_q = data[3:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] gx, input logic [15:0] gy,
                            input logic [15:0] rad, input logic [15:0] ag,
                            input logic [15:0] rg, input logic [3:0] cnt);
    wait_idle();
    write_reg(CFG_GOAL_X, gx);
    write_reg(CFG_GOAL_Y, gy);
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_ATT_GAIN, ag);
    write_reg(CFG_REP_GAIN, rg);
    write_reg(CFG_OBST_COUNT, {12'd0, cnt});
  endtask

  // Evaluate a cell only when every entry in use has been loaded
  task automatic safe_eval(input logic [5:0] cx, input logic [5:0] cy);
    int n;
    n = (obst_count_q > N_OBST) ? N_OBST : obst_count_q;
    for (int i = 0; i < n; i++) if (!obst_loaded[i]) return;
    eval_cell(cx, cy);
  endtask

  task automatic test_reset_defaults();
    eval_cell(6'd0, 6'd0);
    eval_cell(6'd14, 6'd29);
    eval_cell(6'd63, 6'd63);
  endtask

  task automatic test_directed_extremes();
    for (int i = 0; i < N_OBST; i++) load_obstacle(i[2:0], 16'd0, 16'd0);
    load_obstacle(3'd7, 16'hFFFF, 16'hFFFF);
    load_obstacle(3'd2, 16'h0A00, 16'h0A00);
    set_config(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd8);
    // Cells on an obstacle: distance clamped; last, a cell away from every obstacle
    eval_cell(6'd0, 6'd0);
    eval_cell(6'd10, 6'd10);
    eval_cell(6'd63, 6'd0);
    // Count above the table size, smallest radius not below the clamp
    set_config(16'hFFFF, 16'hFFFF, 16'd26, 16'd0, 16'd1, 4'd15);
    eval_cell(6'd0, 6'd0);
    eval_cell(6'd63, 6'd63);
    // Zero radius, then no obstacles in use
    set_config(16'h1234, 16'h0800, 16'd0, 16'd256, 16'hFFFF, 4'd3);
    eval_cell(6'd10, 6'd10);
    set_config(16'h1234, 16'h0800, 16'd2560, 16'd256, 16'hFFFF, 4'd0);
    eval_cell(6'd10, 6'd10);
    eval_cell(6'd63, 6'd0);
  endtask

  task automatic test_random_traffic(input int items);
    int kind;
    logic [5:0] cx, cy;
    for (int i = 0; i < items; i++) begin
      // Stretch with no idling on the sender side
      tx_idle_enable = !(i >= items / 3 && i < items / 3 + 80);
      if (i % 150 == 149) begin
        kind = $urandom_range(3);
        set_config(16'($urandom), 16'($urandom),
                   kind == 0 ? 16'hFFFF : 16'($urandom_range(26, 6000)),
                   kind == 1 ? 16'hFFFF : 16'($urandom),
                   kind == 2 ? 16'd0 : 16'($urandom),
                   4'($urandom_range(15)));
      end
      cx = 6'($urandom);
      cy = 6'($urandom);
      if ($urandom_range(99) < 25) begin
        // Obstacles near the cell grid so repulsion happens often
        load_obstacle(3'($urandom), $urandom_range(3) == 0 ? 16'($urandom) :
                      16'($urandom_range(0, 16383)),
                      $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16383)));
      end else begin
        safe_eval(cx, cy);
      end
    end
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 2000;
    for (int i = 0; i < 30; i++) safe_eval(6'($urandom), 6'($urandom));
  endtask

  // Result sink: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rx_idle_enable && ($urandom_range(99) < 14);
    end
  end

  // Compare each transfer with the oldest expectation
  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        report_mismatch("unexpected result", out_potential, 32'd0);
      end else begin
        want = expected_cells.pop_front();
        if (out_cell_x !== want.cx)
          report_mismatch("cell_x", 32'(out_cell_x), 32'(want.cx));
        if (out_cell_y !== want.cy)
          report_mismatch("cell_y", 32'(out_cell_y), 32'(want.cy));
        if (out_potential !== want.pot) report_mismatch("potential", out_potential, want.pot);
        if (out_saturated !== want.sat)
          report_mismatch("saturated", 32'(out_saturated), 32'(want.sat));
      end
    end
  end

  initial begin
    goal_x_q = 16'd3584;
    goal_y_q = 16'd7424;
    radius_q = 16'd2560;
    att_gain_q = 16'd2560;
    rep_gain_q = 16'd25600;
    obst_count_q = 4'd0;
    obst_loaded = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_extremes();
    rx_idle_enable = 1'b0;
    test_random_traffic(300);
    rx_idle_enable = 1'b1;
    test_random_traffic(820);
    test_backpressure();
    wait_idle();
    if (error_count == 0 && expected_cells.size() == 0)
      $display("potential_field_cell_eval_unit_tb: clean");
    else
      $display("potential_field_cell_eval_unit_tb: errors");
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("potential_field_cell_eval_unit_tb: errors");
    $finish;
  end

endmodule
